// ===== hw/rtl/keyed_top_k_tracker_defines.svh =====
// Assertion macros for the keyed top-k tracker.
// Used by the checker module; holds nothing but macro definitions.
`ifndef KEYED_TOP_K_TRACKER_DEFINES_SVH
`define KEYED_TOP_K_TRACKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KTT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ktt_pkg.sv =====
// Package for the keyed top-k tracker: word types, opcodes, state and control types.
// Has no dependencies; every module of the block and the testbench import it.
`timescale 1ns / 1ps

package ktt_pkg;

   localparam int KEY_W   = 32;
   localparam int SCORE_W = 32;
   localparam int RANK_W  = 4;
   localparam int COUNT_W = 4;

   localparam logic OP_SUBMIT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   typedef struct packed {
      logic                      op;
      logic [KEY_W-1:0]          key;
      logic signed [SCORE_W-1:0] score;
      logic [RANK_W-1:0]         rank;
   } req_word_type;

   typedef struct packed {
      logic                      changed;
      logic                      was_update;
      logic                      would_enter;
      logic [COUNT_W-1:0]        entry_count;
      logic                      read_valid;
      logic [KEY_W-1:0]          read_key;
      logic signed [SCORE_W-1:0] read_score;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_PLACE
   } ktt_state_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic remove_en;
      logic remove_last;
      logic place_en;
   } chain_cmd_type;

   // Summary of the chain as seen by the current word.
   typedef struct packed {
      logic is_read;
      logic found;
      logic same_score;
      logic full;
      logic would_enter;
   } chain_stat_type;

   typedef struct packed {
      logic req_ready;
      logic capture;
      logic load_out;
      logic changed;
      logic was_update;
   } ctrl_out_type;

endpackage

// ===== hw/rtl/keyed_top_k_tracker.sv =====
// Keyed top-k tracker: a chain of cells kept in descending score order.
// A response word is registered after the remove pass and then the place pass over the cell
// chain; a new word is taken only when idle or as the place pass of the last one runs, and the
// place pass waits while a response word is stalled. Reset clears the entry count, the sequencer
// and the response valid; cell contents are left as they are and are never read until written.
`timescale 1ns / 1ps

module keyed_top_k_tracker #(
   parameter int CAPACITY   = 10,
   parameter int KEY_BITS   = 32,
   parameter int SCORE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ktt_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ktt_pkg::rsp_word_type rsp_data
);
   import ktt_pkg::*;

   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = 8;

   req_word_type item_ff;
   rsp_word_type rsp_data_ff;
   logic         rsp_valid_ff;
   logic [CW-1:0] count_ff, count_in;

   logic                         would_enter_ff;
   logic                         read_valid_ff;
   logic [KEY_W-1:0]             read_key_ff;
   logic signed [SCORE_W-1:0]    read_score_ff;

   logic                         req_fire;
   logic                         out_free;
   chain_cmd_type                cmd;
   chain_stat_type               stat;
   ctrl_out_type                 ctl;

   logic [KEY_BITS-1:0]          new_key;
   logic signed [SCORE_BITS-1:0] new_score;

   logic [KEY_BITS-1:0]          cell_key   [CAPACITY];
   logic signed [SCORE_BITS-1:0] cell_score [CAPACITY];
   logic [KEY_BITS-1:0]          prev_key   [CAPACITY];
   logic signed [SCORE_BITS-1:0] prev_score [CAPACITY];
   logic [KEY_BITS-1:0]          next_key   [CAPACITY];
   logic signed [SCORE_BITS-1:0] next_score [CAPACITY];
   logic [CAPACITY-1:0]          occ, occ_next, ge, prev_ge, match, is_last, rm_from, rm_prev;
   logic [CAPACITY-1:0]          rank_hit;

   logic signed [SCORE_BITS-1:0] match_score, last_score, sel_score;
   logic [KEY_BITS-1:0]          sel_key;
   logic                         found;
   logic                         rank_ok;
   logic [KEY_W-1:0]             sel_key_w;
   logic signed [SCORE_W-1:0]    sel_score_w;
   logic [CMP_W-1:0]             count_ext;

   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = ctl.req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Field widths to and from the stored widths.
   if (KEY_BITS <= KEY_W) begin : g_key_narrow
      assign new_key   = item_ff.key[KEY_BITS-1:0];
      assign sel_key_w = KEY_W'(sel_key);
   end else begin : g_key_wide
      assign new_key   = {{(KEY_BITS - KEY_W){1'b0}}, item_ff.key};
      assign sel_key_w = sel_key[KEY_W-1:0];
   end

   if (SCORE_BITS <= SCORE_W) begin : g_score_narrow
      assign new_score   = item_ff.score[SCORE_BITS-1:0];
      assign sel_score_w = SCORE_W'(sel_score);
   end else begin : g_score_wide
      assign new_score   = {{(SCORE_BITS - SCORE_W){item_ff.score[SCORE_W-1]}}, item_ff.score};
      assign sel_score_w = sel_score[SCORE_W-1:0];
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occ[i]      = CMP_W'(i) < CMP_W'(count_ff);
      assign rank_hit[i] = CMP_W'(item_ff.rank) == CMP_W'(i);

      if (i == 0) begin : g_head
         assign prev_key[i]   = new_key;
         assign prev_score[i] = new_score;
         assign prev_ge[i]    = 1'b1;
         assign rm_prev[i]    = 1'b0;
      end else begin : g_body
         assign prev_key[i]   = cell_key[i-1];
         assign prev_score[i] = cell_score[i-1];
         assign prev_ge[i]    = ge[i-1];
         assign rm_prev[i]    = rm_from[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_key[i]   = cell_key[i];
         assign next_score[i] = cell_score[i];
         assign occ_next[i]   = 1'b0;
      end else begin : g_inner
         assign next_key[i]   = cell_key[i+1];
         assign next_score[i] = cell_score[i+1];
         assign occ_next[i]   = occ[i+1];
      end

      ktt_cell #(
         .KEY_BITS   (KEY_BITS),
         .SCORE_BITS (SCORE_BITS)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occ        (occ[i]),
         .occ_next   (occ_next[i]),
         .new_key    (new_key),
         .new_score  (new_score),
         .prev_key   (prev_key[i]),
         .prev_score (prev_score[i]),
         .prev_ge    (prev_ge[i]),
         .next_key   (next_key[i]),
         .next_score (next_score[i]),
         .rm_prev    (rm_prev[i]),
         .key_ff     (cell_key[i]),
         .score_ff   (cell_score[i]),
         .ge         (ge[i]),
         .match      (match[i]),
         .is_last    (is_last[i]),
         .rm_from    (rm_from[i])
      );
   end

   // Each of these selects picks at most one cell; match does so as keys are unique.
   always_comb begin
      found       = 1'b0;
      match_score = '0;
      last_score  = '0;
      sel_key     = '0;
      sel_score   = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         found = found | match[i];
         if (match[i]) begin
            match_score = match_score | cell_score[i];
         end
         if (is_last[i]) begin
            last_score = last_score | cell_score[i];
         end
         if (rank_hit[i]) begin
            sel_key   = sel_key | cell_key[i];
            sel_score = sel_score | cell_score[i];
         end
      end
   end

   assign rank_ok          = CMP_W'(item_ff.rank) < CMP_W'(count_ff);
   assign stat.is_read     = item_ff.op == OP_READ;
   assign stat.found       = found;
   assign stat.same_score  = match_score == new_score;
   assign stat.full        = CMP_W'(count_ff) == CMP_W'(CAPACITY);
   assign stat.would_enter = !stat.full || !(last_score >= new_score);

   ktt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .stat      (stat),
      .cmd       (cmd),
      .ctl       (ctl)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.remove_en) begin
         count_in = count_ff - CW'(1);
      end else if (cmd.place_en) begin
         count_in = count_ff + CW'(1);
      end
   end

   assign count_ext = CMP_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (ctl.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_data;
      end
      if (ctl.capture) begin
         would_enter_ff <= stat.would_enter;
         read_valid_ff  <= stat.is_read && rank_ok;
         read_key_ff    <= (stat.is_read && rank_ok) ? sel_key_w : '0;
         read_score_ff  <= (stat.is_read && rank_ok) ? sel_score_w : '0;
      end
      if (ctl.load_out) begin
         rsp_data_ff.changed     <= ctl.changed;
         rsp_data_ff.was_update  <= ctl.was_update;
         rsp_data_ff.would_enter <= would_enter_ff;
         rsp_data_ff.entry_count <= count_ext[COUNT_W-1:0];
         rsp_data_ff.read_valid  <= read_valid_ff;
         rsp_data_ff.read_key    <= read_key_ff;
         rsp_data_ff.read_score  <= read_score_ff;
      end
   end

endmodule

// ===== hw/rtl/ktt_cell.sv =====
// One cell of the sorted chain: holds a key and score and shifts to either neighbour.
// Depends on ktt_pkg for the broadcast command type.
`timescale 1ns / 1ps

module ktt_cell #(
   parameter int KEY_BITS   = 32,
   parameter int SCORE_BITS = 32
) (
   input  logic                         clock,
   input  ktt_pkg::chain_cmd_type       cmd,
   input  logic                         occ,
   input  logic                         occ_next,
   input  logic [KEY_BITS-1:0]          new_key,
   input  logic signed [SCORE_BITS-1:0] new_score,
   input  logic [KEY_BITS-1:0]          prev_key,
   input  logic signed [SCORE_BITS-1:0] prev_score,
   input  logic                         prev_ge,
   input  logic [KEY_BITS-1:0]          next_key,
   input  logic signed [SCORE_BITS-1:0] next_score,
   input  logic                         rm_prev,
   output logic [KEY_BITS-1:0]          key_ff,
   output logic signed [SCORE_BITS-1:0] score_ff,
   output logic                         ge,
   output logic                         match,
   output logic                         is_last,
   output logic                         rm_from
);
   import ktt_pkg::*;

   logic [KEY_BITS-1:0]          key_in;
   logic signed [SCORE_BITS-1:0] score_in;
   logic                         rm_at;

   assign match   = occ && (key_ff == new_key);
   assign ge      = occ && (score_ff >= new_score);
   assign is_last = occ && !occ_next;
   assign rm_at   = cmd.remove_last ? is_last : match;
   assign rm_from = rm_prev || rm_at;

   // Removal closes the gap from the right; placement opens one after the last
   // entry whose score is at least the new one, so equal scores keep their age order.
   always_comb begin
      key_in   = key_ff;
      score_in = score_ff;
      if (cmd.remove_en && rm_from) begin
         key_in   = next_key;
         score_in = next_score;
      end else if (cmd.place_en && !ge) begin
         if (prev_ge) begin
            key_in   = new_key;
            score_in = new_score;
         end else begin
            key_in   = prev_key;
            score_in = prev_score;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      score_ff <= score_in;
   end

endmodule

// ===== hw/rtl/ktt_ctrl.sv =====
// Sequencer of the tracker: accepts a word, runs the remove pass, then the place pass.
// Depends on ktt_pkg for the state, command, status and control types.
`timescale 1ns / 1ps

module ktt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    out_free,
   input  ktt_pkg::chain_stat_type stat,
   output ktt_pkg::chain_cmd_type  cmd,
   output ktt_pkg::ctrl_out_type   ctl
);
   import ktt_pkg::*;

   ktt_state_type state_ff, state_in;
   logic          pending_ff, pending_in;
   logic          changed_ff, changed_in;
   logic          was_update_ff, was_update_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pending_ff    <= 1'b0;
         changed_ff    <= 1'b0;
         was_update_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pending_ff    <= pending_in;
         changed_ff    <= changed_in;
         was_update_ff <= was_update_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      pending_in     = pending_ff;
      changed_in     = changed_ff;
      was_update_in  = was_update_ff;
      cmd            = '0;
      ctl            = '0;
      ctl.changed    = changed_ff;
      ctl.was_update = was_update_ff;
      case (state_ff)
         ST_IDLE: begin
            ctl.req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_REMOVE;
            end
         end
         ST_REMOVE: begin
            state_in      = ST_PLACE;
            ctl.capture   = 1'b1;
            pending_in    = 1'b0;
            changed_in    = 1'b0;
            was_update_in = 1'b0;
            if (!stat.is_read) begin
               was_update_in = stat.found;
               if (stat.found) begin
                  if (!stat.same_score) begin
                     cmd.remove_en = 1'b1;
                     pending_in    = 1'b1;
                     changed_in    = 1'b1;
                  end
               end else if (!stat.full) begin
                  pending_in = 1'b1;
                  changed_in = 1'b1;
               end else if (stat.would_enter) begin
                  // Full table: the lowest-ranked entry gives way.
                  cmd.remove_en   = 1'b1;
                  cmd.remove_last = 1'b1;
                  pending_in      = 1'b1;
                  changed_in      = 1'b1;
               end
            end
         end
         ST_PLACE: begin
            // The place pass waits until the output register can take the word.
            if (out_free) begin
               cmd.place_en  = pending_ff;
               ctl.load_out  = 1'b1;
               ctl.req_ready = 1'b1;
               state_in      = req_valid ? ST_REMOVE : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/ktt_checker.sv =====
// Port-level checks for the keyed top-k tracker, bound to its top level.
// Depends on ktt_pkg and the assertion macros in keyed_top_k_tracker_defines.svh.
`timescale 1ns / 1ps
`include "keyed_top_k_tracker_defines.svh"

module ktt_checker #(
   parameter int CAPACITY = 10
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input ktt_pkg::rsp_word_type rsp_data
);
   import ktt_pkg::*;

   // A stalled response word must hold.
   `KTT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response word changed while stalled")

   // The table never holds more than its capacity.
   `KTT_ASSERT_SAME(a_count_bound, clock, reset, rsp_valid, (CAPACITY > 15) || (rsp_data.entry_count <= CAPACITY), "entry count above capacity")

   // A successful read leaves the table untouched.
   `KTT_ASSERT_SAME(a_read_clean, clock, reset, rsp_valid && rsp_data.read_valid, !rsp_data.changed && !rsp_data.was_update, "read word reports a table change")

   // A new key can only change the table if it would enter.
   `KTT_ASSERT_SAME(a_change_cause, clock, reset, rsp_valid && rsp_data.changed, rsp_data.would_enter || rsp_data.was_update, "table changed by a key that could not enter")

   // Without a valid read the read fields are zero.
   `KTT_ASSERT_SAME(a_read_zero, clock, reset, rsp_valid && !rsp_data.read_valid, (rsp_data.read_key == '0) && (rsp_data.read_score == '0), "read fields not zero")

endmodule

bind keyed_top_k_tracker ktt_checker #(
   .CAPACITY (CAPACITY)
) u_ktt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_keyed_top_k_tracker.sv =====
// Self-checking testbench for keyed_top_k_tracker: keeps a shadow leaderboard and checks
// every response word against it. Depends on ktt_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_keyed_top_k_tracker;
   import ktt_pkg::*;

   localparam int TABLE_DEPTH  = 10;
   localparam int RANDOM_WORDS = 400;
   localparam int REPLY_HOLD   = 150;
   localparam int TAIL_CYCLES  = 8;
   localparam int CYCLE_LIMIT  = 200000;

   // Shadow copy of the leaderboard, kept in rank order, plus the replies it predicts.
   class leaderboard_shadow;
      logic [KEY_W-1:0]          slot_key[TABLE_DEPTH];
      logic signed [SCORE_W-1:0] slot_score[TABLE_DEPTH];
      int unsigned               held = 0;
      rsp_word_type              awaited[$];
      int                        errors = 0;
      int                        checked = 0;
      int                        submits = 0;
      int                        reads = 0;
      int                        evictions = 0;
      int                        dropped = 0;

      function void drop_slot(int unsigned idx);
         for (int unsigned j = idx; j + 1 < held; j++) begin
            slot_key[j]   = slot_key[j + 1];
            slot_score[j] = slot_score[j + 1];
         end
         held--;
      endfunction

      // A newly placed entry goes below every entry with an equal or higher score.
      function void insert_ranked(logic [KEY_W-1:0] k, logic signed [SCORE_W-1:0] s);
         int unsigned p;
         p = 0;
         while (p < held && slot_score[p] >= s) p++;
         for (int unsigned j = held; j > p; j--) begin
            slot_key[j]   = slot_key[j - 1];
            slot_score[j] = slot_score[j - 1];
         end
         slot_key[p]   = k;
         slot_score[p] = s;
         held++;
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type              r;
         logic signed [SCORE_W-1:0] s;
         int unsigned               hit;
         bit                        found;
         r     = '0;
         s     = w.score;
         found = 1'b0;
         hit   = 0;
         if (held < TABLE_DEPTH) begin
            r.would_enter = 1'b1;
         end else begin
            r.would_enter = (s > slot_score[held - 1]);
         end
         if (w.op == OP_SUBMIT) begin
            submits++;
            for (int unsigned i = 0; i < held; i++) begin
               if (!found && slot_key[i] == w.key) begin
                  found = 1'b1;
                  hit   = i;
               end
            end
            if (found) begin
               r.was_update = 1'b1;
               if (slot_score[hit] != s) begin
                  drop_slot(hit);
                  insert_ranked(w.key, s);
                  r.changed = 1'b1;
               end
            end else if (held < TABLE_DEPTH) begin
               insert_ranked(w.key, s);
               r.changed = 1'b1;
            end else if (r.would_enter) begin
               drop_slot(held - 1);
               insert_ranked(w.key, s);
               r.changed = 1'b1;
               evictions++;
            end else begin
               dropped++;
            end
         end else begin
            reads++;
            if (w.rank < held) begin
               r.read_valid = 1'b1;
               r.read_key   = slot_key[w.rank];
               r.read_score = slot_score[w.rank];
            end
         end
         r.entry_count = held[COUNT_W-1:0];
         awaited.insert(awaited.size(), r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_reply(rsp_word_type got);
         rsp_word_type want;
         if (awaited.size() == 0) begin
            $error("response word with nothing outstanding: %p", got);
            errors++;
            return;
         end
         want = awaited.pop_front();
         checked++;
         compare_field("changed", want.changed, got.changed);
         compare_field("was_update", want.was_update, got.was_update);
         compare_field("would_enter", want.would_enter, got.would_enter);
         compare_field("entry_count", want.entry_count, got.entry_count);
         compare_field("read_valid", want.read_valid, got.read_valid);
         compare_field("read_key", want.read_key, got.read_key);
         compare_field("read_score", want.read_score, got.read_score);
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_data;

   leaderboard_shadow board = new();
   logic [KEY_W-1:0]  key_pool[16];
   bit                steady_send = 1'b0;
   bit                hold_replies = 1'b0;
   int unsigned       cycle_count = 0;

   keyed_top_k_tracker #(
      .CAPACITY(TABLE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_keyed_top_k_tracker: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_reply(rsp_data);
   end

   // Response side: random stalls, the odd long one, calm stretches, and one long hold-off
   // while the sender keeps pushing, so that the block backs up into its input.
   initial begin
      int unsigned r;
      int unsigned sink_cycles;
      rsp_ready   = 1'b0;
      sink_cycles = 0;
      forever begin
         @(negedge clock);
         sink_cycles++;
         r = $urandom_range(0, 99);
         if (hold_replies) begin
            rsp_ready <= 1'b0;
            repeat (REPLY_HOLD) @(negedge clock);
            hold_replies = 1'b0;
         end else if ((sink_cycles / 200) % 3 == 1) begin
            rsp_ready <= 1'b1;
         end else if (r < 3) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(5, 25)) @(negedge clock);
         end else begin
            rsp_ready <= (r < 70);
         end
      end
   end

   // Called at a falling edge; returns at a falling edge with the word accepted.
   task automatic send_word(input req_word_type w);
      int unsigned pick;
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      gap  = 0;
      pick = $urandom_range(0, 99);
      if (!steady_send) begin
         if (pick >= 90) gap = $urandom_range(5, 20);
         else if (pick >= 55) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic submit_word(input logic [KEY_W-1:0] k, input logic [SCORE_W-1:0] s);
      req_word_type w;
      w       = '0;
      w.op    = OP_SUBMIT;
      w.key   = k;
      w.score = s;
      w.rank  = RANK_W'($urandom_range(0, 15));
      send_word(w);
   endtask

   task automatic read_word(input logic [RANK_W-1:0] rk, input logic [SCORE_W-1:0] s);
      req_word_type w;
      w       = '0;
      w.op    = OP_READ;
      w.key   = $urandom;
      w.score = s;
      w.rank  = rk;
      send_word(w);
   endtask

   initial begin
      req_word_type w;
      int unsigned  pick;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 16; i++) key_pool[i] = $urandom;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reads of an empty table, then a fill with ties and extremes of key and score.
      read_word(4'd0, 32'h7fff_ffff);
      read_word(4'd15, 32'h8000_0000);
      submit_word(32'h0000_0000, 32'd0);
      submit_word(32'hffff_ffff, 32'h7fff_ffff);
      submit_word(32'h0000_0001, 32'h8000_0000);
      submit_word(32'h0000_0002, 32'd0);
      // Same score again leaves the table alone; a lower score moves the entry down.
      submit_word(32'h0000_0000, 32'd0);
      submit_word(32'h0000_0000, -32'sd5);
      for (int i = 3; i < 9; i++) submit_word(i, i * 10);
      // Full table: a score equal to the lowest is turned away, a higher one evicts it.
      submit_word(32'h0000_0100, 32'h8000_0000);
      submit_word(32'h0000_0101, 32'd3);
      submit_word(32'h0000_0102, 32'd3);
      submit_word(32'h0000_0003, 32'h8000_0000);
      read_word(4'd0, 32'h8000_0000);
      read_word(4'd9, 32'h7fff_ffff);
      read_word(4'd10, 32'd0);
      read_word(4'd15, -32'sd1);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         steady_send = ((i / 40) % 3 == 0);
         if (i == 120) hold_replies = 1'b1;
         w      = '0;
         w.op   = ($urandom_range(0, 99) < 30) ? OP_READ : OP_SUBMIT;
         w.key  = ($urandom_range(0, 99) < 80) ? key_pool[4'($urandom_range(0, 15))]
                                               : $urandom;
         w.rank = RANK_W'($urandom_range(0, 15));
         pick   = $urandom_range(0, 99);
         if (pick < 40) begin
            w.score = int'($urandom_range(0, 16)) - 8;
         end else if (pick < 80) begin
            w.score = $urandom;
         end else begin
            case ($urandom_range(0, 3))
               0: w.score = 32'h8000_0000;
               1: w.score = 32'h7fff_ffff;
               2: w.score = '1;
               default: w.score = '0;
            endcase
         end
         send_word(w);
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d submits and %0d reads; %0d response words checked.",
               board.submits, board.reads, board.checked);
      $display("The full table saw %0d evictions and turned away %0d new keys.",
               board.evictions, board.dropped);
      if (board.errors == 0) begin
         $display("tb_keyed_top_k_tracker: done, clean");
      end else begin
         $display("tb_keyed_top_k_tracker: done, errors");
      end
      $finish;
   end

endmodule

// ===== keyed_top_k_tracker.f =====
+incdir+hw/rtl
hw/rtl/ktt_pkg.sv
hw/rtl/ktt_cell.sv
hw/rtl/ktt_ctrl.sv
hw/rtl/keyed_top_k_tracker.sv
hw/rtl/ktt_checker.sv
tb/tb_keyed_top_k_tracker.sv
